/* hdl/gaas_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, register map and arctangent table for the aim angle solver.
// No dependencies.
package gaas_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ANGLE_W = 32;
	localparam int TAB_N = 32;
	localparam int PADDR_W = 5;

	// atan(2^-i) in Q.16 degrees, rounded to nearest
	localparam logic signed [ANGLE_W-1:0] ATAN_TAB [TAB_N] = '{
		32'sd2949120, 32'sd1740967, 32'sd919879, 32'sd466945,
		32'sd234379, 32'sd117304, 32'sd58666, 32'sd29335,
		32'sd14668, 32'sd7334, 32'sd3667, 32'sd1833,
		32'sd917, 32'sd458, 32'sd229, 32'sd115,
		32'sd57, 32'sd29, 32'sd14, 32'sd7,
		32'sd4, 32'sd2, 32'sd1, 32'sd0,
		32'sd0, 32'sd0, 32'sd0, 32'sd0,
		32'sd0, 32'sd0, 32'sd0, 32'sd0
	};

	localparam logic [23:0] RANGE_MAX = 24'hFFFFFF;
	localparam logic [23:0] TIME_MAX = 24'hFFFFFF;
	localparam logic [33:0] GAIN_Q30 = 34'd652032874;
	localparam logic [15:0] GAIN_Q16 = 16'd39797;
	localparam logic [31:0] DEAD_Q16 = 32'd1310;
	localparam logic [14:0] PITCH_RIGHT = 15'd23040;
	localparam logic [16:0] PITCH_STRAIGHT = 17'd46080;

	typedef enum logic [2:0] {
		REG_TARGET_HEIGHT = 3'd0,
		REG_FOCAL_LENGTH = 3'd1,
		REG_SPEED_SCALE = 3'd2,
		REG_IMAGE_WIDTH = 3'd3,
		REG_IMAGE_HEIGHT = 3'd4
	} reg_idx_t;

	localparam logic [15:0] TARGET_HEIGHT_RST = 16'd1408;
	localparam logic [15:0] FOCAL_LENGTH_RST = 16'd16000;
	localparam logic [15:0] SPEED_SCALE_RST = 16'd4096;
	localparam logic [11:0] IMAGE_WIDTH_RST = 12'd1280;
	localparam logic [11:0] IMAGE_HEIGHT_RST = 12'd1024;

endpackage

/* hdl/gaas_div.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, with a side payload.
// Quotient must fit Q_W bits (caller saturates otherwise). Depends on nothing.
module gaas_div #(
	parameter int NUM_W = 32,
	parameter int DEN_W = 16,
	parameter int Q_W = 24,
	parameter int SIDE_W = 1
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [NUM_W-1:0] num,
	input logic [DEN_W-1:0] den,
	input logic [SIDE_W-1:0] side_in,
	output logic out_valid,
	output logic [Q_W-1:0] quo,
	output logic [SIDE_W-1:0] side_out
);

	localparam int EXT_W = NUM_W + DEN_W;

	logic [EXT_W-1:0] num_ext;
	logic [DEN_W-1:0] rem_s [Q_W];
	logic [Q_W-1:0] lo_s [Q_W];
	logic [DEN_W-1:0] den_s [Q_W];
	logic [SIDE_W-1:0] side_s [Q_W];
	logic vld_s [Q_W];

	assign num_ext = {{DEN_W{1'b0}}, num};

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		logic [DEN_W-1:0] rem_i;
		logic [DEN_W-1:0] den_i;
		logic [Q_W-1:0] lo_i;
		logic [SIDE_W-1:0] side_i;
		logic vld_i;
		logic [DEN_W:0] trial;
		logic take;

		if (k == 0) begin : g_first
			assign rem_i = DEN_W'(num_ext >> Q_W);
			assign lo_i = num[Q_W-1:0];
			assign den_i = den;
			assign side_i = side_in;
			assign vld_i = in_valid;
		end else begin : g_next
			assign rem_i = rem_s[k-1];
			assign lo_i = lo_s[k-1];
			assign den_i = den_s[k-1];
			assign side_i = side_s[k-1];
			assign vld_i = vld_s[k-1];
		end

		assign trial = {rem_i, lo_i[Q_W-1]};
		assign take = trial >= {1'b0, den_i};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k] <= take ? DEN_W'(trial - {1'b0, den_i}) : trial[DEN_W-1:0];
			lo_s[k] <= {lo_i[Q_W-2:0], take};
			den_s[k] <= den_i;
			side_s[k] <= side_i;
		end
	end

	assign out_valid = vld_s[Q_W-1];
	assign quo = lo_s[Q_W-1];
	assign side_out = side_s[Q_W-1];

endmodule

/* hdl/gaas_cordic.sv */
`timescale 1ns / 1ps
// Pipelined CORDIC, one micro-rotation per stage, rotation or vectoring mode.
// Depends on gaas_pkg for the arctangent table.
module gaas_cordic #(
	parameter int XW = 48,
	parameter int STAGES = gaas_pkg::CORDIC_STAGES_DEF,
	parameter bit VECTOR = 1'b1,
	parameter int SIDE_W = 1
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic signed [XW-1:0] x_in,
	input logic signed [XW-1:0] y_in,
	input logic signed [gaas_pkg::ANGLE_W-1:0] a_in,
	input logic [SIDE_W-1:0] side_in,
	output logic out_valid,
	output logic signed [XW-1:0] x_out,
	output logic signed [gaas_pkg::ANGLE_W-1:0] a_out,
	output logic [SIDE_W-1:0] side_out
);

	logic signed [XW-1:0] x_s [STAGES];
	logic signed [XW-1:0] y_s [STAGES];
	logic signed [gaas_pkg::ANGLE_W-1:0] a_s [STAGES];
	logic [SIDE_W-1:0] side_s [STAGES];
	logic vld_s [STAGES];

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		logic signed [XW-1:0] x_i;
		logic signed [XW-1:0] y_i;
		logic signed [gaas_pkg::ANGLE_W-1:0] a_i;
		logic [SIDE_W-1:0] side_i;
		logic vld_i;
		logic signed [XW-1:0] xs;
		logic signed [XW-1:0] ys;
		logic dir;

		if (k == 0) begin : g_first
			assign x_i = x_in;
			assign y_i = y_in;
			assign a_i = a_in;
			assign side_i = side_in;
			assign vld_i = in_valid;
		end else begin : g_next
			assign x_i = x_s[k-1];
			assign y_i = y_s[k-1];
			assign a_i = a_s[k-1];
			assign side_i = side_s[k-1];
			assign vld_i = vld_s[k-1];
		end

		assign xs = x_i >>> k;
		assign ys = y_i >>> k;
		assign dir = VECTOR ? y_i[XW-1] : !a_i[gaas_pkg::ANGLE_W-1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (dir) begin
				x_s[k] <= x_i - ys;
				y_s[k] <= y_i + xs;
				a_s[k] <= a_i - gaas_pkg::ATAN_TAB[k];
			end else begin
				x_s[k] <= x_i + ys;
				y_s[k] <= y_i - xs;
				a_s[k] <= a_i + gaas_pkg::ATAN_TAB[k];
			end
			side_s[k] <= side_i;
		end
	end

	assign out_valid = vld_s[STAGES-1];
	assign x_out = x_s[STAGES-1];
	assign a_out = a_s[STAGES-1];
	assign side_out = side_s[STAGES-1];

endmodule

/* hdl/gimbal_aim_angle_solver_top.sv */
`timescale 1ns / 1ps
// Aim angle solver top level: APB register file and the full solver pipeline.
// Depends on gaas_pkg, gaas_div and gaas_cordic.
// The solver takes one target box per clock: busy never rises, and each box
// yields exactly one result on the done strobe. The path from start to done
// runs through the three divider pipelines (range 24 stages, offsets 40
// stages, flight time 24 stages) and three CORDIC pipelines (pitch cosine,
// yaw, pitch), plus ten staging registers. Results cannot be held off;
// capture them on the cycle done is high. Write configuration only while no
// box is in flight.
module gimbal_aim_angle_solver_top #(
	parameter int CORDIC_STAGES = gaas_pkg::CORDIC_STAGES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [gaas_pkg::PADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic start,
	output logic busy,
	input logic [15:0] box_center_x,
	input logic [15:0] box_center_y,
	input logic [15:0] box_height,
	input logic [15:0] bullet_speed,
	input logic signed [15:0] gimbal_pitch,
	output logic done,
	output logic signed [15:0] yaw_angle,
	output logic signed [15:0] pitch_angle,
	output logic [23:0] target_range,
	output logic invalid
);

	localparam int LAT = 98 + 3 * CORDIC_STAGES;
	localparam int COS_W = 34;
	localparam int VEC_W = 48;

	typedef struct packed {
		logic bhz;
		logic rsat;
		logic [31:0] vss;
		logic [14:0] ap;
		logic [15:0] adx;
		logic dxn;
		logic [15:0] adz;
		logic dzn;
	} side_a_t;

	typedef struct packed {
		logic bhz;
		logic ap90;
		logic [23:0] rng;
		logic [31:0] vss;
		logic [15:0] adx;
		logic dxn;
		logic [15:0] adz;
		logic dzn;
	} side_b_t;

	typedef struct packed {
		logic inv;
		logic [39:0] den;
		logic [23:0] rng;
		logic dxn;
	} side_c_t;

	typedef struct packed {
		logic inv;
		logic tsat;
		logic [23:0] rng;
		logic signed [40:0] x;
		logic signed [40:0] z;
	} side_d_t;

	typedef struct packed {
		logic inv;
		logic yz;
		logic [23:0] rng;
		logic signed [42:0] zt;
	} side_e_t;

	typedef struct packed {
		logic inv;
		logic pz;
		logic [23:0] rng;
		logic signed [31:0] ya;
	} side_f_t;

	function automatic logic signed [15:0] to_q88(input logic signed [31:0] a);
		logic [31:0] mag;
		logic signed [31:0] r;
		begin
			mag = a[31] ? 32'(-a) : 32'(a);
			r = (a + 32'sd128) >>> 8;
			if (mag <= gaas_pkg::DEAD_Q16) begin
				return 16'sd0;
			end
			return r[15:0];
		end
	endfunction

	// Configuration registers
	logic [15:0] target_height_q;
	logic [15:0] focal_length_q;
	logic [15:0] speed_scale_q;
	logic [11:0] image_width_q;
	logic [11:0] image_height_q;
	logic wr_en;
	gaas_pkg::reg_idx_t reg_idx;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;
	assign reg_idx = gaas_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_height_q <= gaas_pkg::TARGET_HEIGHT_RST;
			focal_length_q <= gaas_pkg::FOCAL_LENGTH_RST;
			speed_scale_q <= gaas_pkg::SPEED_SCALE_RST;
			image_width_q <= gaas_pkg::IMAGE_WIDTH_RST;
			image_height_q <= gaas_pkg::IMAGE_HEIGHT_RST;
		end else if (wr_en) begin
			case (reg_idx)
				gaas_pkg::REG_TARGET_HEIGHT: target_height_q <= pwdata[15:0];
				gaas_pkg::REG_FOCAL_LENGTH: focal_length_q <= pwdata[15:0];
				gaas_pkg::REG_SPEED_SCALE: speed_scale_q <= pwdata[15:0];
				gaas_pkg::REG_IMAGE_WIDTH: image_width_q <= pwdata[11:0];
				gaas_pkg::REG_IMAGE_HEIGHT: image_height_q <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			gaas_pkg::REG_TARGET_HEIGHT: prdata = {16'b0, target_height_q};
			gaas_pkg::REG_FOCAL_LENGTH: prdata = {16'b0, focal_length_q};
			gaas_pkg::REG_SPEED_SCALE: prdata = {16'b0, speed_scale_q};
			gaas_pkg::REG_IMAGE_WIDTH: prdata = {20'b0, image_width_q};
			gaas_pkg::REG_IMAGE_HEIGHT: prdata = {20'b0, image_height_q};
			default: prdata = 32'b0;
		endcase
	end

	// Stage 1: capture transaction, products, offsets and folded pitch
	logic acc;
	logic signed [17:0] dx_c;
	logic signed [17:0] dz_c;
	logic signed [16:0] ps_ext;
	logic [16:0] ap_abs;
	logic [14:0] ap_fold;

	logic v_s1;
	logic [31:0] fh_s1;
	logic [15:0] bh_s1;
	logic [31:0] vss_s1;
	logic [14:0] ap_s1;
	logic [15:0] adx_s1;
	logic dxn_s1;
	logic [15:0] adz_s1;
	logic dzn_s1;

	assign busy = 1'b0;
	assign acc = start && !busy;

	always_comb begin
		dx_c = $signed({2'b00, box_center_x}) - $signed({3'b000, image_width_q, 3'b000});
		dz_c = $signed({3'b000, image_height_q, 3'b000}) - $signed({2'b00, box_center_y});
		ps_ext = {gimbal_pitch[15], gimbal_pitch};
		ap_abs = ps_ext[16] ? 17'(-ps_ext) : 17'(ps_ext);
		ap_fold = (ap_abs > 17'(gaas_pkg::PITCH_RIGHT)) ?
			15'(gaas_pkg::PITCH_STRAIGHT - ap_abs) : ap_abs[14:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		fh_s1 <= 32'(focal_length_q) * 32'(target_height_q);
		bh_s1 <= box_height;
		vss_s1 <= 32'(bullet_speed) * 32'(speed_scale_q);
		ap_s1 <= ap_fold;
		adx_s1 <= dx_c[17] ? 16'(-dx_c) : dx_c[15:0];
		dxn_s1 <= dx_c[17];
		adz_s1 <= dz_c[17] ? 16'(-dz_c) : dz_c[15:0];
		dzn_s1 <= dz_c[17];
	end

	// Range divider
	side_a_t a_in;
	side_a_t a_out;
	logic a_vld;
	logic [23:0] q_rng;

	always_comb begin
		a_in.bhz = bh_s1 == 16'd0;
		a_in.rsat = {8'b0, fh_s1[31:24]} >= bh_s1;
		a_in.vss = vss_s1;
		a_in.ap = ap_s1;
		a_in.adx = adx_s1;
		a_in.dxn = dxn_s1;
		a_in.adz = adz_s1;
		a_in.dzn = dzn_s1;
	end

	gaas_div #(
		.NUM_W(32),
		.DEN_W(16),
		.Q_W(24),
		.SIDE_W($bits(side_a_t))
	) u_div_rng (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v_s1),
		.num(fh_s1),
		.den(bh_s1),
		.side_in(a_in),
		.out_valid(a_vld),
		.quo(q_rng),
		.side_out(a_out)
	);

	// Pitch cosine
	side_b_t b_in;
	side_b_t b_out;
	logic b_vld;
	logic signed [COS_W-1:0] cos_x;
	logic signed [gaas_pkg::ANGLE_W-1:0] cos_a;

	always_comb begin
		b_in.bhz = a_out.bhz;
		b_in.ap90 = a_out.ap == gaas_pkg::PITCH_RIGHT;
		b_in.rng = a_out.rsat ? gaas_pkg::RANGE_MAX : q_rng;
		b_in.vss = a_out.vss;
		b_in.adx = a_out.adx;
		b_in.dxn = a_out.dxn;
		b_in.adz = a_out.adz;
		b_in.dzn = a_out.dzn;
	end

	gaas_cordic #(
		.XW(COS_W),
		.STAGES(CORDIC_STAGES),
		.VECTOR(1'b0),
		.SIDE_W($bits(side_b_t))
	) u_cos (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(a_vld),
		.x_in($signed(gaas_pkg::GAIN_Q30)),
		.y_in('0),
		.a_in($signed({9'b0, a_out.ap, 8'b0})),
		.side_in(b_in),
		.out_valid(b_vld),
		.x_out(cos_x),
		.a_out(cos_a),
		.side_out(b_out)
	);

	// Stages 2-4: clamp cosine, scaled speed, denominator and offset numerators
	logic v_s2;
	logic [16:0] c16_s2;
	side_b_t b_s2;
	logic v_s3;
	logic [48:0] vsc_s3;
	side_b_t b_s3;
	logic v_s4;
	logic inv_s4;
	logic [39:0] den_s4;
	logic [39:0] nx_s4;
	logic [39:0] nz_s4;
	logic [23:0] rng_s4;
	logic dxn_s4;
	logic dzn_s4;
	logic [55:0] v100;

	assign v100 = (56'(vsc_s3) << 6) + (56'(vsc_s3) << 5) + (56'(vsc_s3) << 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s2 <= b_vld;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (cos_x[COS_W-1] || cos_a[gaas_pkg::ANGLE_W-1] && 1'b0) begin
			c16_s2 <= 17'd0;
		end else if (cos_x > 34'sd1073741824) begin
			c16_s2 <= 17'd65536;
		end else begin
			c16_s2 <= cos_x[30:14];
		end
		b_s2 <= b_out;
		vsc_s3 <= 49'(b_s2.vss) * 49'(c16_s2);
		b_s3 <= b_s2;
		inv_s4 <= b_s3.bhz || b_s3.ap90 || (vsc_s3 == 49'd0);
		den_s4 <= v100[55:16];
		nx_s4 <= 40'(b_s3.adx) * 40'(b_s3.rng);
		nz_s4 <= 40'(b_s3.adz) * 40'(b_s3.rng);
		rng_s4 <= b_s3.rng;
		dxn_s4 <= b_s3.dxn;
		dzn_s4 <= b_s3.dzn;
	end

	// Offset dividers
	side_c_t c_in;
	side_c_t c_out;
	logic c_vld;
	logic z_vld;
	logic z_neg;
	logic [39:0] q_x;
	logic [39:0] q_z;

	always_comb begin
		c_in.inv = inv_s4;
		c_in.den = den_s4;
		c_in.rng = rng_s4;
		c_in.dxn = dxn_s4;
	end

	gaas_div #(
		.NUM_W(40),
		.DEN_W(16),
		.Q_W(40),
		.SIDE_W($bits(side_c_t))
	) u_div_x (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v_s4),
		.num(nx_s4),
		.den(focal_length_q),
		.side_in(c_in),
		.out_valid(c_vld),
		.quo(q_x),
		.side_out(c_out)
	);

	gaas_div #(
		.NUM_W(40),
		.DEN_W(16),
		.Q_W(40),
		.SIDE_W(1)
	) u_div_z (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v_s4),
		.num(nz_s4),
		.den(focal_length_q),
		.side_in(dzn_s4),
		.out_valid(z_vld),
		.quo(q_z),
		.side_out(z_neg)
	);

	// Stage 5: signed offsets and flight time saturation
	logic v_s5;
	logic inv_s5;
	logic tsat_s5;
	logic [39:0] den_s5;
	logic [23:0] rng_s5;
	logic signed [40:0] x_s5;
	logic signed [40:0] z_s5;
	logic fz;

	assign fz = focal_length_q == 16'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= c_vld && z_vld;
		end
	end

	always_ff @(posedge clk) begin
		inv_s5 <= c_out.inv;
		tsat_s5 <= {12'b0, c_out.rng, 4'b0} >= c_out.den;
		den_s5 <= c_out.den;
		rng_s5 <= c_out.rng;
		if (fz) begin
			x_s5 <= '0;
			z_s5 <= '0;
		end else begin
			x_s5 <= c_out.dxn ? -$signed({1'b0, q_x}) : $signed({1'b0, q_x});
			z_s5 <= z_neg ? -$signed({1'b0, q_z}) : $signed({1'b0, q_z});
		end
	end

	// Flight time divider
	side_d_t d_in;
	side_d_t d_out;
	logic d_vld;
	logic [23:0] q_t;

	always_comb begin
		d_in.inv = inv_s5;
		d_in.tsat = tsat_s5;
		d_in.rng = rng_s5;
		d_in.x = x_s5;
		d_in.z = z_s5;
	end

	gaas_div #(
		.NUM_W(52),
		.DEN_W(40),
		.Q_W(24),
		.SIDE_W($bits(side_d_t))
	) u_div_t (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v_s5),
		.num({rng_s5, 28'b0}),
		.den(den_s5),
		.side_in(d_in),
		.out_valid(d_vld),
		.quo(q_t),
		.side_out(d_out)
	);

	// Stages 6-8: gravity drop and total vertical offset
	logic [23:0] t_c;
	logic v_s6;
	logic [47:0] tt_s6;
	logic inv_s6;
	logic [23:0] rng_s6;
	logic signed [40:0] x_s6;
	logic signed [40:0] z_s6;
	logic v_s7;
	logic [32:0] drop_s7;
	logic inv_s7;
	logic [23:0] rng_s7;
	logic signed [40:0] x_s7;
	logic signed [40:0] z_s7;
	logic v_s8;
	logic signed [42:0] zt_s8;
	logic inv_s8;
	logic [23:0] rng_s8;
	logic signed [VEC_W-1:0] ny_s8;
	logic yz_s8;
	logic [56:0] m490;

	assign t_c = d_out.tsat ? gaas_pkg::TIME_MAX : q_t;
	assign m490 = (57'(tt_s6) << 9) - (57'(tt_s6) << 4) - (57'(tt_s6) << 2)
		- (57'(tt_s6) << 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			v_s6 <= d_vld;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		tt_s6 <= 48'(t_c) * 48'(t_c);
		inv_s6 <= d_out.inv;
		rng_s6 <= d_out.rng;
		x_s6 <= d_out.x;
		z_s6 <= d_out.z;
		drop_s7 <= m490[56:24];
		inv_s7 <= inv_s6;
		rng_s7 <= rng_s6;
		x_s7 <= x_s6;
		z_s7 <= z_s6;
		zt_s8 <= 43'(z_s7) + $signed({10'b0, drop_s7});
		inv_s8 <= inv_s7;
		rng_s8 <= rng_s7;
		ny_s8 <= -VEC_W'(x_s7);
		yz_s8 <= (rng_s7 == 24'd0) && (x_s7 == 41'sd0);
	end

	// Yaw arctangent
	side_e_t e_in;
	side_e_t e_out;
	logic e_vld;
	logic signed [VEC_W-1:0] yaw_x;
	logic signed [gaas_pkg::ANGLE_W-1:0] yaw_a;

	always_comb begin
		e_in.inv = inv_s8;
		e_in.yz = yz_s8;
		e_in.rng = rng_s8;
		e_in.zt = zt_s8;
	end

	gaas_cordic #(
		.XW(VEC_W),
		.STAGES(CORDIC_STAGES),
		.VECTOR(1'b1),
		.SIDE_W($bits(side_e_t))
	) u_yaw (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v_s8),
		.x_in($signed({24'b0, rng_s8})),
		.y_in(ny_s8),
		.a_in('0),
		.side_in(e_in),
		.out_valid(e_vld),
		.x_out(yaw_x),
		.a_out(yaw_a),
		.side_out(e_out)
	);

	// Stage 9: hypotenuse for the pitch step
	logic signed [VEC_W-1:0] g_eff;
	logic [62:0] hyp_prod;
	logic v_s9;
	logic [46:0] hyp_s9;
	logic signed [31:0] ya_s9;
	logic inv_s9;
	logic [23:0] rng_s9;
	logic signed [VEC_W-1:0] nz_s9;
	logic pz_s9;

	assign g_eff = e_out.yz ? '0 : yaw_x;
	assign hyp_prod = 63'(g_eff[46:0]) * 63'(gaas_pkg::GAIN_Q16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else begin
			v_s9 <= e_vld;
		end
	end

	always_ff @(posedge clk) begin
		hyp_s9 <= hyp_prod[62:16];
		ya_s9 <= e_out.yz ? 32'sd0 : yaw_a;
		inv_s9 <= e_out.inv;
		rng_s9 <= e_out.rng;
		nz_s9 <= -VEC_W'(e_out.zt);
		pz_s9 <= (g_eff[VEC_W-1:1] == '0) && (e_out.zt == 43'sd0);
	end

	// Pitch arctangent
	side_f_t f_in;
	side_f_t f_out;
	logic f_vld;
	logic signed [VEC_W-1:0] pit_x;
	logic signed [gaas_pkg::ANGLE_W-1:0] pit_a;
	logic signed [31:0] pa_c;

	always_comb begin
		f_in.inv = inv_s9;
		f_in.pz = pz_s9;
		f_in.rng = rng_s9;
		f_in.ya = ya_s9;
	end

	gaas_cordic #(
		.XW(VEC_W),
		.STAGES(CORDIC_STAGES),
		.VECTOR(1'b1),
		.SIDE_W($bits(side_f_t))
	) u_pitch (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v_s9),
		.x_in($signed({1'b0, hyp_s9})),
		.y_in(nz_s9),
		.a_in('0),
		.side_in(f_in),
		.out_valid(f_vld),
		.x_out(pit_x),
		.a_out(pit_a),
		.side_out(f_out)
	);

	assign pa_c = (f_out.pz || pit_x[VEC_W-1] && 1'b0) ? 32'sd0 : pit_a;

	// Output register
	logic done_q;
	logic signed [15:0] yaw_q;
	logic signed [15:0] pitch_q;
	logic [23:0] range_q;
	logic invalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= f_vld;
		end
	end

	always_ff @(posedge clk) begin
		yaw_q <= f_out.inv ? 16'sd0 : to_q88(f_out.ya);
		pitch_q <= f_out.inv ? 16'sd0 : to_q88(pa_c);
		range_q <= f_out.rng;
		invalid_q <= f_out.inv;
	end

	assign done = done_q;
	assign yaw_angle = yaw_q;
	assign pitch_angle = pitch_q;
	assign target_range = range_q;
	assign invalid = invalid_q;

	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> ##LAT done)
		else $error("transaction did not complete at fixed latency");

	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		!acc |-> ##LAT !done)
		else $error("result strobe without a transaction");

	a_zero_h: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && box_height == 16'd0) |->
		##LAT (invalid && target_range == gaas_pkg::RANGE_MAX))
		else $error("zero box height not flagged with saturated range");

	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && invalid) |-> (yaw_angle == 16'sd0 && pitch_angle == 16'sd0))
		else $error("invalid result carries nonzero angles");

endmodule
